/* sv/aes_pkg.sv */
// Shared AES constants, types and byte-level functions.
package aes_pkg;

   localparam int NumRounds   = 10;
   localparam int BlockBytes  = 16;
   localparam int WordBits    = 64;
   localparam int KeyWords    = 2 * (NumRounds + 1);
   localparam int KeyAddrBits = $clog2(KeyWords);
   localparam int RoundBits   = $clog2(NumRounds + 1);
   localparam int ByteIdxBits = $clog2(BlockBytes);

   typedef logic [7:0]              byte_type;
   typedef logic [KeyAddrBits-1:0]  key_addr_type;
   typedef logic [RoundBits-1:0]    round_type;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   localparam logic OpEncrypt = 1'b0;
   localparam logic OpDecrypt = 1'b1;

   // Multiply by x in GF(2^8).
   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type gf_mul(input byte_type a, input logic [3:0] b);
      byte_type p;
      byte_type x;
      p = '0;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gf_mul = p;
   endfunction

   function automatic byte_type sbox(input byte_type x);
      byte_type t [256] = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

   function automatic byte_type inv_sbox(input byte_type x);
      byte_type t [256] = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = t[x];
   endfunction

endpackage

/* sv/aes_stream_if.sv */
// Valid/ready channel carrying one cipher item.
interface aes_stream_if #(parameter int PayloadWidth = 129);
   logic                    valid;
   logic                    ready;
   logic [PayloadWidth-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/aes_ram.sv */
// Generic single-port RAM with registered read.
module aes_ram #(
   parameter int Width = 64,
   parameter int Depth = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

/* sv/aes_block_cipher_unit.sv */
// Byte-serial AES-128 engine: key expansion, ten rounds, 16-byte state shift line.
// Each item makes 11 passes: each pass fetches its round key as two words from the key RAM
// and then processes the 16 state bytes; the nine middle rounds add a four-column mix pass.
// The first item after reset or a key write first expands and stores all 11 round keys.
// Items are taken only when idle; a waiting result does not block the next item, only its result.
// Reset: synchronous; clears control state and keys_ready, key registers to zero.
module aes128_block_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_write_data,
   aes_stream_if.sink   req,
   aes_stream_if.source rsp
);
   import aes_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_KEXP, S_KWR, S_FETCH, S_ROUND, S_MIX, S_DONE
   } state_type;

   state_type                state_ff;
   logic [63:0]              key_hi_ff, key_lo_ff;
   logic                     keys_ready_ff;
   logic                     op_ff;
   logic [127:0]             st_ff;     // state, byte 0 in [127:120]
   logic [127:0]             rk_ff;     // round key being applied / generated
   round_type                round_ff;
   logic [ByteIdxBits-1:0]   cnt_ff;
   logic                     half_ff;
   byte_type                 rc_ff;
   logic [127:0]             res_ff;
   logic                     rsp_valid_ff;
   logic                     loaded_ff;

   // Round key store.
   logic         ram_we;
   key_addr_type ram_addr;
   logic [63:0]  ram_wdata, ram_rdata;
   aes_ram #(.Width(WordBits), .Depth(KeyWords)) u_ram (
      .clock, .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wdata), .rd_data(ram_rdata));

   // Key schedule byte step: byte j of next key from prev key bytes.
   byte_type kb_in;
   always_comb begin
      byte_type t;
      logic [1:0] r;
      r = cnt_ff[1:0];
      if (cnt_ff < 4) begin
         // rotated last word of the previous key; it has moved up by j bytes
         t = sbox(rk_ff[127 - 8*(12 + ((r + 1) & 3) - r) -: 8]);
         if (r == 0) t = t ^ rc_ff;
         t = t ^ rk_ff[127 -: 8];
      end else begin
         // previous byte of the new key is 4 positions back, now at [31:0] end
         t = rk_ff[127 -: 8] ^ rk_ff[31 -: 8];
      end
      kb_in = t;
   end

   // Round byte step: byte at head of state line.
   byte_type sb;
   byte_type hb;
   always_comb begin
      hb = st_ff[127 -: 8];
      sb = (op_ff == OpEncrypt) ? sbox(hb) : inv_sbox(hb);
   end

   // Shift rows on whole state (wiring only).
   function automatic logic [127:0] shrow(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      o = s;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            if (inv)
               o[127 - 8*(r + 4*((c + r) & 3)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
            else
               o[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) & 3)) -: 8];
      return o;
   endfunction

   // Mix one column at head of line (column = 4 bytes).
   logic [31:0] mix_col;
   always_comb begin
      byte_type a [4];
      for (int j = 0; j < 4; j++) a[j] = st_ff[127 - 8*j -: 8];
      for (int r = 0; r < 4; r++) begin
         if (op_ff == OpEncrypt)
            mix_col[31 - 8*r -: 8] = gf_mul(a[r], 4'd2) ^ gf_mul(a[(r+1)&3], 4'd3)
                                     ^ a[(r+2)&3] ^ a[(r+3)&3];
         else
            mix_col[31 - 8*r -: 8] = gf_mul(a[r], 4'd14) ^ gf_mul(a[(r+1)&3], 4'd11)
                                     ^ gf_mul(a[(r+2)&3], 4'd13) ^ gf_mul(a[(r+3)&3], 4'd9);
      end
   end

   logic last_round;
   logic first_pass;
   logic key_byte_en;
   round_type key_round;
   assign first_pass = (round_ff == '0);
   assign last_round = (round_ff == round_type'(NumRounds));
   assign key_round  = (op_ff == OpEncrypt) ? round_ff : round_type'(NumRounds) - round_ff;
   // Middle encrypt rounds add the key in the mix pass, after the column mix.
   assign key_byte_en = first_pass || last_round || (op_ff == OpDecrypt);

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = half_ff ? rk_ff[63:0] : rk_ff[127:64];
      ram_addr  = key_addr_type'({round_ff, half_ff});
      unique case (state_ff)
         S_KWR:   ram_we = 1'b1;
         S_FETCH: ram_addr = key_addr_type'({key_round, half_ff});
         default: ;
      endcase
   end

   // Take a new item whenever idle; res_ff holds the previous result meanwhile.
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; key_hi_ff <= '0; key_lo_ff <= '0;
         keys_ready_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         cnt_ff <= '0; half_ff <= 1'b0; round_ff <= '0; loaded_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            keys_ready_ff <= 1'b0;
            unique case (csr_index)
               CsrKeyHigh: key_hi_ff <= csr_write_data;
               CsrKeyLow:  key_lo_ff <= csr_write_data;
            endcase
         end else if (state_ff == S_KWR && half_ff && last_round) begin
            // last round key stored: mark the schedule valid
            keys_ready_ff <= 1'b1;
         end
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               op_ff <= req.data[128];
               st_ff <= req.data[127:0];
               round_ff <= '0; half_ff <= 1'b0; cnt_ff <= '0;
               if (keys_ready_ff) state_ff <= S_FETCH;
               else begin
                  // write round key 0 straight from the key registers
                  rk_ff <= {key_hi_ff, key_lo_ff}; rc_ff <= 8'h01;
                  state_ff <= S_KWR;
               end
            end
            S_KWR: begin
               // store both halves, then build the next key unless this was the last
               half_ff <= ~half_ff;
               if (half_ff) begin
                  if (last_round) begin
                     round_ff <= '0; state_ff <= S_FETCH;
                  end else begin
                     round_ff <= round_ff + 1'b1; cnt_ff <= '0; state_ff <= S_KEXP;
                  end
               end
            end
            S_KEXP: begin
               // rotate the key one byte, replacing the head with the new byte
               rk_ff <= {rk_ff[119:0], kb_in};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ByteIdxBits'(BlockBytes - 1)) begin
                  rc_ff <= xtime(rc_ff); state_ff <= S_KWR;
               end
            end
            S_FETCH: begin
               // two words: present the address, then take the registered read data in the next cycle
               if (loaded_ff) begin
                  if (half_ff) rk_ff[63:0] <= ram_rdata; else rk_ff[127:64] <= ram_rdata;
                  half_ff <= ~half_ff; loaded_ff <= 1'b0;
                  if (half_ff) begin
                     cnt_ff <= '0;
                     // shift rows commutes with the byte substitution; apply it up front
                     if (!first_pass) st_ff <= shrow(st_ff, op_ff == OpDecrypt);
                     state_ff <= S_ROUND;
                  end
               end else loaded_ff <= 1'b1;
            end
            S_ROUND: begin
               // per byte: substitute (except first pass), add key where due
               st_ff <= {st_ff[119:0], (first_pass ? hb : sb)
                         ^ (key_byte_en ? rk_ff[127 - 8*cnt_ff -: 8] : 8'h00)};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ByteIdxBits'(BlockBytes - 1)) begin
                  if (last_round) state_ff <= S_DONE;
                  else if (!first_pass) state_ff <= S_MIX;
                  else begin round_ff <= round_ff + 1'b1; state_ff <= S_FETCH; end
               end
            end
            S_MIX: begin
               // one column per cycle; encrypt adds the round key after the mix
               st_ff <= {st_ff[95:0], mix_col
                         ^ ((op_ff == OpEncrypt) ? rk_ff[127 - 32*cnt_ff -: 32] : 32'h0)};
               if (cnt_ff == ByteIdxBits'(3)) begin
                  cnt_ff <= '0; round_ff <= round_ff + 1'b1; state_ff <= S_FETCH;
               end else cnt_ff <= cnt_ff + 1'b1;
            end
            S_DONE: if (!rsp_valid_ff) begin
               res_ff <= st_ff; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_one_item;
      @(posedge clock) disable iff (reset) (req.valid && req.ready) |=> !req.ready;
   endproperty
   a_one_item: assert property (p_one_item) else $error("item accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.data))
      else $error("result dropped");
   a_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> keys_ready_ff || csr_write_enable || $past(csr_write_enable))
      else $error("round without keys");
endmodule
